### hdl/spat_pkg.sv
// ----------------------------------------------------------------------------
// spat_pkg: shared types and constants
// beat layouts, stored entry layout, operation and status codes
// ----------------------------------------------------------------------------
`default_nettype none

package spat_pkg;

	localparam int MZ_W    = 30;
	localparam int INTEN_W = 40;
	localparam int CNT_W   = 20;

	// operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_MERGED    = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_BAD_INDEX = 3'd5;

	// x / 10 == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int          RECIP10_SHIFT = 35;

	typedef struct packed {
		logic [1:0]  operation;
		logic [29:0] mz_value;
		logic [31:0] peak_intensity;
		logic [15:0] peak_count;
		logic [9:0]  read_index;
	} in_beat_t;

	typedef struct packed {
		logic [29:0] entry_mz;
		logic [39:0] entry_intensity;
		logic [19:0] entry_count;
		logic [10:0] entries_used;
		logic [2:0]  status;
	} out_beat_t;

	typedef struct packed {
		logic [MZ_W-1:0]    mz;
		logic [INTEN_W-1:0] inten;
		logic [CNT_W-1:0]   cnt;
	} entry_t;

endpackage

`default_nettype wire

### hdl/spat_ram.sv
// ----------------------------------------------------------------------------
// spat_ram: generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module spat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/sorted_peak_accumulation_table_core.sv
// ----------------------------------------------------------------------------
// sorted_peak_accumulation_table_core: sorted m/z peak accumulation table
// entries kept in one ram in ascending key order; add merges or inserts,
// remove subtracts and deletes at count zero, read returns one position
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        input      in_valid/in_stall  spat_pkg::in_beat_t
//  out       output     out_valid/out_stall spat_pkg::out_beat_t
//  cfg       input      cfg_we             cfg_wdata (round enable)
//
//  read and clear need no scan; add and remove find the sorted position by a
//  linear scan of the ram, then move each tail entry in turn when an insert or
//  delete shifts the tail.
//  the single ram read port sets the scan and the shift at one entry a cycle
//  reset clears the fill count and control at once; the ram is not cleared
//  a stalled result beat does not block the next input beat; only a second
//  result waiting behind it holds the core in its final step
`default_nettype none

module sorted_peak_accumulation_table_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire spat_pkg::in_beat_t  in_beat,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output spat_pkg::out_beat_t      out_beat,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata
);

	import spat_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int UW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_MUL  = 11'b000_0000_0010,
		S_KEY  = 11'b000_0000_0100,
		S_DISP = 11'b000_0000_1000,
		S_RD   = 11'b000_0001_0000,
		S_SRCH = 11'b000_0010_0000,
		S_RES  = 11'b000_0100_0000,
		S_SHUP = 11'b000_1000_0000,
		S_INS  = 11'b001_0000_0000,
		S_SHDN = 11'b010_0000_0000,
		S_DONE = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	// captured beat
	logic [1:0]  op_q, op_d;
	logic [29:0] mz_q, mz_d;
	logic [31:0] inten_q, inten_d;
	logic [15:0] cnt_q, cnt_d;
	logic [9:0]  idx_q, idx_d;

	// rounding: product register, then key
	logic [62:0] prod_q, prod_d;
	logic [29:0] key_q, key_d;
	logic        round_q;

	// table bookkeeping
	logic [UW-1:0] used_q, used_d;
	logic [AW-1:0] ev_q, ev_d;   // address whose read data arrives this cycle
	logic [AW-1:0] sh_q, sh_d;   // shift read pointer
	logic [UW-1:0] pos_q, pos_d; // first position not below the key
	logic          eq_q, eq_d;   // entry at pos_q holds the key
	entry_t        hit_q, hit_d;

	out_beat_t res_q, res_d;
	out_beat_t out_q, out_d;
	logic      out_valid_q, out_valid_d;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;

	spat_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// datapath helpers
	logic [27:0] quot;
	logic [29:0] rounded;
	logic [40:0] sum_i;
	logic [20:0] sum_c;
	logic [39:0] merged_i, rem_i;
	logic [19:0] merged_c, rem_c;
	entry_t      new_entry;
	logic        full;

	assign quot     = prod_q[62:RECIP10_SHIFT];
	assign rounded  = 30'({quot, 3'b000}) + 30'({quot, 1'b0});
	assign sum_i    = {1'b0, hit_q.inten} + 41'(inten_q);
	assign sum_c    = {1'b0, hit_q.cnt} + 21'(cnt_q);
	assign merged_i = sum_i[40] ? '1 : sum_i[39:0];
	assign merged_c = sum_c[20] ? '1 : sum_c[19:0];
	// remove clamps intensity at zero and count at zero
	assign rem_i    = (hit_q.inten > 40'(inten_q)) ? hit_q.inten - 40'(inten_q) : '0;
	assign rem_c    = (hit_q.cnt != '0) ? hit_q.cnt - 20'd1 : '0;
	assign new_entry = '{mz: key_q, inten: 40'(inten_q), cnt: 20'(cnt_q)};
	assign full     = (used_q == UW'(TABLE_DEPTH));

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		mz_d        = mz_q;
		inten_d     = inten_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		prod_d      = prod_q;
		key_d       = key_q;
		used_d      = used_q;
		ev_d        = ev_q;
		sh_d        = sh_q;
		pos_d       = pos_q;
		eq_d        = eq_q;
		hit_d       = hit_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		ram_we      = 1'b0;
		ram_waddr   = AW'(pos_q);
		ram_wdata   = new_entry;
		ram_raddr   = '0;

		// result beat taken downstream
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d    = in_beat.operation;
					mz_d    = in_beat.mz_value;
					inten_d = in_beat.peak_intensity;
					cnt_d   = in_beat.peak_count;
					idx_d   = in_beat.read_index;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				// (mz + 5) / 10 by reciprocal
				prod_d  = ({1'b0, mz_q} + 31'd5) * RECIP10;
				state_d = S_KEY;
			end
			S_KEY: begin
				key_d   = round_q ? rounded : mz_q;
				state_d = S_DISP;
			end
			S_DISP: begin
				unique case (op_q)
					OP_CLEAR: begin
						used_d  = '0;
						res_d   = '0;
						res_d.status = ST_OK;
						state_d = S_DONE;
					end
					OP_READ: begin
						if (32'(idx_q) < 32'(used_q)) begin
							ram_raddr = AW'(idx_q);
							state_d   = S_RD;
						end else begin
							res_d   = '0;
							res_d.status = ST_BAD_INDEX;
							state_d = S_DONE;
						end
					end
					OP_ADD, OP_REMOVE: begin
						if (used_q == '0) begin
							pos_d   = '0;
							eq_d    = 1'b0;
							state_d = S_RES;
						end else begin
							ram_raddr = '0;
							ev_d      = '0;
							state_d   = S_SRCH;
						end
					end
				endcase
			end
			S_RD: begin
				res_d.entry_mz        = ram_rdata.mz;
				res_d.entry_intensity = ram_rdata.inten;
				res_d.entry_count     = ram_rdata.cnt;
				res_d.status          = ST_OK;
				state_d               = S_DONE;
			end
			S_SRCH: begin
				// streaming scan: evaluate ev_q, fetch ev_q + 1
				priority if (ram_rdata.mz >= key_q) begin
					pos_d   = UW'(ev_q);
					eq_d    = (ram_rdata.mz == key_q);
					hit_d   = ram_rdata;
					state_d = S_RES;
				end else if (UW'(ev_q) + UW'(1) == used_q) begin
					pos_d   = used_q;
					eq_d    = 1'b0;
					state_d = S_RES;
				end else begin
					ram_raddr = ev_q + AW'(1);
					ev_d      = ev_q + AW'(1);
				end
			end
			S_RES: begin
				res_d.entry_mz = key_q;
				if (op_q == OP_ADD) begin
					priority if (eq_q) begin
						ram_we    = 1'b1;
						ram_wdata = '{mz: key_q, inten: merged_i, cnt: merged_c};
						res_d.entry_intensity = merged_i;
						res_d.entry_count     = merged_c;
						res_d.status          = ST_MERGED;
						state_d               = S_DONE;
					end else if (full) begin
						res_d.entry_intensity = '0;
						res_d.entry_count     = '0;
						res_d.status          = ST_FULL;
						state_d               = S_DONE;
					end else if (pos_q == used_q) begin
						ram_we  = 1'b1;
						used_d  = used_q + UW'(1);
						res_d.entry_intensity = new_entry.inten;
						res_d.entry_count     = new_entry.cnt;
						res_d.status          = ST_INSERTED;
						state_d               = S_DONE;
					end else begin
						// open a slot: move tail up, top entry first
						ram_raddr = AW'(used_q - UW'(1));
						sh_d      = AW'(used_q - UW'(1));
						state_d   = S_SHUP;
					end
				end else begin
					priority if (!eq_q) begin
						res_d.entry_intensity = '0;
						res_d.entry_count     = '0;
						res_d.status          = ST_NOT_FOUND;
						state_d               = S_DONE;
					end else if (rem_c != '0) begin
						ram_we    = 1'b1;
						ram_wdata = '{mz: key_q, inten: rem_i, cnt: rem_c};
						res_d.entry_intensity = rem_i;
						res_d.entry_count     = rem_c;
						res_d.status          = ST_OK;
						state_d               = S_DONE;
					end else begin
						res_d.entry_intensity = rem_i;
						res_d.entry_count     = '0;
						res_d.status          = ST_OK;
						if (pos_q + UW'(1) < used_q) begin
							// close the gap: move tail down
							ram_raddr = AW'(pos_q + UW'(1));
							sh_d      = AW'(pos_q + UW'(1));
							state_d   = S_SHDN;
						end else begin
							used_d  = used_q - UW'(1);
							state_d = S_DONE;
						end
					end
				end
			end
			S_SHUP: begin
				ram_we    = 1'b1;
				ram_waddr = sh_q + AW'(1);
				ram_wdata = ram_rdata;
				if (UW'(sh_q) == pos_q) begin
					state_d = S_INS;
				end else begin
					ram_raddr = sh_q - AW'(1);
					sh_d      = sh_q - AW'(1);
				end
			end
			S_INS: begin
				ram_we  = 1'b1;
				used_d  = used_q + UW'(1);
				res_d.entry_intensity = new_entry.inten;
				res_d.entry_count     = new_entry.cnt;
				res_d.status          = ST_INSERTED;
				state_d               = S_DONE;
			end
			S_SHDN: begin
				ram_we    = 1'b1;
				ram_waddr = sh_q - AW'(1);
				ram_wdata = ram_rdata;
				if (UW'(sh_q) + UW'(1) == used_q) begin
					used_d  = used_q - UW'(1);
					state_d = S_DONE;
				end else begin
					ram_raddr = sh_q + AW'(1);
					sh_d      = sh_q + AW'(1);
				end
			end
			S_DONE: begin
				// wait only while an older result still sits in the output register
				if (!out_valid_q || !out_stall) begin
					out_d              = res_q;
					out_d.entries_used = 11'(used_q);
					out_valid_d        = 1'b1;
					state_d            = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			round_q     <= 1'b1;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				round_q <= cfg_wdata;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		mz_q    <= mz_d;
		inten_q <= inten_d;
		cnt_q   <= cnt_d;
		idx_q   <= idx_d;
		prod_q  <= prod_d;
		key_q   <= key_d;
		ev_q    <= ev_d;
		sh_q    <= sh_d;
		pos_q   <= pos_d;
		eq_q    <= eq_d;
		hit_q   <= hit_d;
		res_q   <= res_d;
		out_q   <= out_d;
	end

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_shup_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHUP |-> (UW'(sh_q) >= pos_q && UW'(sh_q) < used_q))
		else $error("insert shift pointer outside tail");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> UW'(ram_waddr) <= used_q)
		else $error("ram write beyond end of table");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_peak_accumulation_table_core
// drives add, remove, read and clear beats with random gaps and output stalls,
// tracks the sorted table in a local shadow and checks every result beat
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spat_pkg::*;

	// full-size table, as the block is used
	localparam int DEPTH     = 1024;
	localparam int FILL      = 12;
	localparam int WD_LIMIT  = 4000;
	localparam int SETTLE    = 2 * DEPTH + 20;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_stall;
	in_beat_t  in_beat = '0;
	logic      out_valid;
	logic      out_stall = 0;
	out_beat_t out_beat;
	logic      cfg_we = 0;
	logic      cfg_wdata = 0;

	sorted_peak_accumulation_table_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow of the table contents and of the rounding register
	logic [29:0] shadow_key [DEPTH];
	logic [39:0] shadow_inten [DEPTH];
	logic [19:0] shadow_cnt [DEPTH];
	int          shadow_used = 0;
	logic        shadow_round = 1;

	in_beat_t  pending_beats [$];
	out_beat_t expected_results [$];
	int        errors = 0;
	int        beats_in = 0;
	int        beats_out = 0;
	int        status_seen [8];
	bit        no_idle = 0;
	logic [29:0] key_pool [20];

	// append one beat to the pending list
	function automatic void enqueue(in_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	// compute the result of one beat and update the shadow table
	function automatic out_beat_t apply_table_op(in_beat_t b);
		out_beat_t r;
		logic [31:0] k;
		logic [40:0] s;
		logic [20:0] c;
		logic [39:0] ni;
		logic [19:0] nc;
		int pos;
		r = '0;
		k = {2'b00, b.mz_value};
		if (shadow_round)
			k = ((k + 32'd5) / 32'd10) * 32'd10;
		pos = 0;
		while (pos < shadow_used && {2'b00, shadow_key[pos]} < k)
			pos++;
		case (b.operation)
			OP_ADD: begin
				if (pos < shadow_used && {2'b00, shadow_key[pos]} == k) begin
					s = {1'b0, shadow_inten[pos]} + {9'd0, b.peak_intensity};
					c = {1'b0, shadow_cnt[pos]} + {5'd0, b.peak_count};
					shadow_inten[pos] = s[40] ? '1 : s[39:0];
					shadow_cnt[pos] = c[20] ? '1 : c[19:0];
					r = '{k[29:0], shadow_inten[pos], shadow_cnt[pos], 11'(shadow_used),
						ST_MERGED};
				end else if (shadow_used >= DEPTH) begin
					r = '{k[29:0], 40'd0, 20'd0, 11'(shadow_used), ST_FULL};
				end else begin
					for (int i = shadow_used; i > pos; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_inten[i] = shadow_inten[i-1];
						shadow_cnt[i] = shadow_cnt[i-1];
					end
					shadow_key[pos] = k[29:0];
					shadow_inten[pos] = {8'd0, b.peak_intensity};
					shadow_cnt[pos] = {4'd0, b.peak_count};
					shadow_used++;
					r = '{k[29:0], {8'd0, b.peak_intensity}, {4'd0, b.peak_count},
						11'(shadow_used), ST_INSERTED};
				end
			end
			OP_REMOVE: begin
				if (pos >= shadow_used || {2'b00, shadow_key[pos]} != k) begin
					r = '{k[29:0], 40'd0, 20'd0, 11'(shadow_used), ST_NOT_FOUND};
				end else begin
					ni = (shadow_inten[pos] > {8'd0, b.peak_intensity}) ?
						shadow_inten[pos] - {8'd0, b.peak_intensity} : 40'd0;
					nc = (shadow_cnt[pos] > 0) ? shadow_cnt[pos] - 20'd1 : 20'd0;
					if (nc == 0) begin
						// entry emptied: close the gap in the sorted order
						for (int i = pos; i + 1 < shadow_used; i++) begin
							shadow_key[i] = shadow_key[i+1];
							shadow_inten[i] = shadow_inten[i+1];
							shadow_cnt[i] = shadow_cnt[i+1];
						end
						shadow_used--;
					end else begin
						shadow_inten[pos] = ni;
						shadow_cnt[pos] = nc;
					end
					r = '{k[29:0], ni, nc, 11'(shadow_used), ST_OK};
				end
			end
			OP_READ: begin
				if (b.read_index < shadow_used)
					r = '{shadow_key[b.read_index], shadow_inten[b.read_index],
						shadow_cnt[b.read_index], 11'(shadow_used), ST_OK};
				else
					r = '{30'd0, 40'd0, 20'd0, 11'(shadow_used), ST_BAD_INDEX};
			end
			default: begin
				shadow_used = 0;
				r = '{30'd0, 40'd0, 20'd0, 11'd0, ST_OK};
			end
		endcase
		return r;
	endfunction

	// driver: loads the next pending beat after a random gap, holds it while stalled
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(), apply_table_op(in_beat));
				beats_in++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 0;
				end else if (pending_beats.size() > 0) begin
					in_beat <= pending_beats.pop_front();
					in_valid <= 1;
					gap_left <= no_idle ? 0 : $urandom_range(0, 4);
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor: random stall per beat, every accepted beat checked in order
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		int n;
		if (!arst_n) begin
			out_stall <= 0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_out++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: %p", out_beat);
					errors++;
				end else begin
					e = expected_results.pop_front();
					status_seen[e.status]++;
					if (out_beat.entry_mz !== e.entry_mz) begin
						$error("entry_mz exp %0d got %0d", e.entry_mz, out_beat.entry_mz);
						errors++;
					end
					if (out_beat.entry_intensity !== e.entry_intensity) begin
						$error("entry_intensity exp %0d got %0d", e.entry_intensity,
							out_beat.entry_intensity);
						errors++;
					end
					if (out_beat.entry_count !== e.entry_count) begin
						$error("entry_count exp %0d got %0d", e.entry_count,
							out_beat.entry_count);
						errors++;
					end
					if (out_beat.entries_used !== e.entries_used) begin
						$error("entries_used exp %0d got %0d", e.entries_used,
							out_beat.entries_used);
						errors++;
					end
					if (out_beat.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_beat.status);
						errors++;
					end
				end
				n = no_idle ? 0 : $urandom_range(0, 4);
				stall_left <= (n > 0) ? n - 1 : 0;
				out_stall <= (n > 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	// watchdog: cycles with no beat moving on either side
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (arst_n && (pending_beats.size() > 0 || expected_results.size() > 0 || in_valid))
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", WD_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic in_beat_t mk(logic [1:0] op, logic [29:0] mz, logic [31:0] inten,
		logic [15:0] cnt, logic [9:0] idx);
		in_beat_t b;
		b = '{op, mz, inten, cnt, idx};
		return b;
	endfunction

	// mostly pooled keys so adds, merges and removes meet each other
	function automatic in_beat_t random_beat();
		int sel;
		logic [29:0] mz;
		logic [31:0] inten;
		sel = $urandom_range(0, 99);
		mz = key_pool[$urandom_range(0, 19)];
		if ($urandom_range(0, 2) == 0)
			mz = mz + 30'($urandom_range(0, 9));
		if ($urandom_range(0, 15) == 0)
			mz = 30'($urandom);
		inten = $urandom;
		if ($urandom_range(0, 7) == 0)
			inten = '1;
		if (sel < 45)
			return mk(OP_ADD, mz, inten, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom),
				10'($urandom));
		else if (sel < 75)
			return mk(OP_REMOVE, mz, inten, 16'($urandom), 10'($urandom));
		else if (sel < 96)
			return mk(OP_READ, 30'($urandom), 32'($urandom), 16'($urandom),
				($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)));
		else
			return mk(OP_CLEAR, 30'($urandom), 32'($urandom), 16'($urandom), 10'($urandom));
	endfunction

	task automatic drain();
		while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_rounding(logic v);
		drain();
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		shadow_round = v;
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			enqueue(random_beat());
		drain();
	endtask

	initial begin
		for (int i = 0; i < 20; i++)
			key_pool[i] = (i < 4) ? 30'($urandom) : 30'($urandom_range(0, 2000) * 10);
		key_pool[0] = '1;
		key_pool[1] = 30'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: rounding at its reset value of 1
		enqueue(mk(OP_READ, '1, '1, '1, 10'd0));          // empty table read
		enqueue(mk(OP_ADD, '1, '1, '1, '1));              // largest key and fields
		enqueue(mk(OP_ADD, 30'd0, 32'd0, 16'd0, 10'd0));  // zero count entry
		enqueue(mk(OP_ADD, 30'd14, 32'd100, 16'd3, 10'd0)); // rounds down
		enqueue(mk(OP_ADD, 30'd15, 32'd200, 16'd1, 10'd0)); // tie rounds up
		enqueue(mk(OP_ADD, 30'd24, 32'd50, 16'd2, 10'd0));  // merge into 20
		for (int i = 1; i <= FILL; i++)
			enqueue(mk(OP_ADD, 30'(i * 1000), 32'(i), 16'd1, 10'd0));
		enqueue(mk(OP_ADD, 30'd777, 32'd5, 16'd1, 10'd0)); // insert mid table
		enqueue(mk(OP_ADD, 30'd20, '1, '1, 10'd0));        // merge with large sums
		enqueue(mk(OP_READ, 30'd0, 32'd0, 16'd0, 10'd16));
		enqueue(mk(OP_READ, 30'd0, 32'd0, 16'd0, 10'd17));  // one past the last entry
		enqueue(mk(OP_READ, 30'd0, 32'd0, 16'd0, '1));
		enqueue(mk(OP_REMOVE, 30'd3, 32'd9, 16'd0, 10'd0));     // count zero entry
		enqueue(mk(OP_REMOVE, 30'd10, '1, 16'd0, 10'd0));       // clamps at zero
		enqueue(mk(OP_REMOVE, 30'd7777, 32'd1, 16'd0, 10'd0));  // not found
		enqueue(mk(OP_CLEAR, 30'd0, 32'd0, 16'd0, 10'd0));
		drain();

		// saturation run: repeated maximal adds on one key push both sums to their ceilings
		enqueue(mk(OP_CLEAR, 30'd0, 32'd0, 16'd0, 10'd0));
		for (int i = 0; i < 260; i++)
			enqueue(mk(OP_ADD, 30'd12340, '1, '1, 10'd0));
		enqueue(mk(OP_REMOVE, 30'd12340, 32'd1, 16'd0, 10'd0));
		drain();

		write_rounding(0);
		random_phase(90);
		no_idle = 1;
		random_phase(40);
		no_idle = 0;
		write_rounding(1);
		random_phase(90);
		write_rounding(0);
		random_phase(60);

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d beats in, %0d out, rounding on and off, table depth %0d",
			beats_in, beats_out, DEPTH);
		$display("status mix: ok %0d ins %0d merge %0d miss %0d full %0d badidx %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			status_seen[5]);
		if (errors == 0 && expected_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
